// ----- rtl/arpc_pkg.sv -----
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants for the ARP cache and responder.
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int ENTRIES   = 16;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int IP_W      = 32;
    localparam int MAC_W     = 48;
    localparam int OPER_W    = 16;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_W     = 48;

    localparam logic [CFG_IDX_W-1:0] REG_OWN_IP  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC = CFG_IDX_W'(1);

    localparam logic              ACT_PACKET   = 1'b0;
    localparam logic              ACT_LOOKUP   = 1'b1;
    localparam logic              KIND_REPLY   = 1'b0;
    localparam logic              KIND_REQUEST = 1'b1;
    localparam logic [OPER_W-1:0] OPER_REQUEST = OPER_W'(1);
    localparam logic [MAC_W-1:0]  MAC_BCAST    = {MAC_W{1'b1}};

    typedef struct packed {
        logic              action;
        logic              frame_complete;
        logic [OPER_W-1:0] oper;
        logic [IP_W-1:0]   sender_ip;
        logic [MAC_W-1:0]  sender_mac;
        logic [IP_W-1:0]   tgt_ip;
        logic [IP_W-1:0]   query_ip;
        logic              silent;
    } req_word_t;

    typedef struct packed {
        logic             lookup_hit;
        logic [MAC_W-1:0] lookup_mac;
        logic             send_valid;
        logic             send_kind;
        logic [MAC_W-1:0] send_dest_mac;
        logic [IP_W-1:0]  send_dest_ip;
        logic             insert_dropped;
    } rsp_word_t;

    typedef struct packed {
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } entry_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
    } tbl_cmd_t;

    typedef enum logic [2:0] {
        S_IDLE    = 3'b001,
        S_SCAN    = 3'b010,
        S_RESOLVE = 3'b100
    } state_t;

endpackage

// ----- rtl/arpc_req_if.sv -----
// ----------------------------------------------------------------------------
// arpc_req_if
// Valid/ready channel carrying one input word.
// ----------------------------------------------------------------------------
interface arpc_req_if;
    logic               valid;
    logic               ready;
    arpc_pkg::req_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/arpc_rsp_if.sv -----
// ----------------------------------------------------------------------------
// arpc_rsp_if
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface arpc_rsp_if;
    logic               valid;
    logic               ready;
    arpc_pkg::rsp_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/arpc_table.sv -----
// ----------------------------------------------------------------------------
// arpc_table
// Single-port-write, registered-read memory holding IP/MAC pairs.
// ----------------------------------------------------------------------------
module arpc_table (
    input  logic               clk,
    input  arpc_pkg::tbl_cmd_t cmd,
    output arpc_pkg::entry_t   rd_data
);

    arpc_pkg::entry_t mem [arpc_pkg::ENTRIES];

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr] <= cmd.wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data <= mem[cmd.rd_addr];
        end
    end

endmodule

// ----- rtl/arpc_engine.sv -----
// ----------------------------------------------------------------------------
// arpc_engine
// Sequencer: walks the table for lookups and complete frames, resolves the item, writes back, drives result.
// ----------------------------------------------------------------------------
module arpc_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    arpc_req_if.sink                      req,
    arpc_rsp_if.source                    rsp,
    input  logic [arpc_pkg::IP_W-1:0]     own_ip,
    output arpc_pkg::tbl_cmd_t            tbl_cmd,
    input  arpc_pkg::entry_t              tbl_rd_data
);

    arpc_pkg::state_t                 state_reg, state_next;
    arpc_pkg::req_word_t              item_reg, item_next;
    logic [arpc_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic                             pend_reg, pend_next;
    logic [arpc_pkg::IDX_W-1:0]       pend_idx_reg, pend_idx_next;
    logic                             found_reg, found_next;
    logic [arpc_pkg::IDX_W-1:0]       found_idx_reg, found_idx_next;
    logic [arpc_pkg::MAC_W-1:0]       found_mac_reg, found_mac_next;
    logic                             free_reg, free_next;
    logic [arpc_pkg::IDX_W-1:0]       free_idx_reg, free_idx_next;
    logic [arpc_pkg::ENTRIES-1:0]     valid_reg, valid_next;
    logic                             out_valid_reg, out_valid_next;
    arpc_pkg::rsp_word_t              out_reg, out_next;

    logic [arpc_pkg::IP_W-1:0]        key;
    logic                             load;
    arpc_pkg::rsp_word_t              res;

    assign key       = (item_reg.action == arpc_pkg::ACT_LOOKUP) ? item_reg.query_ip
                                                                 : item_reg.sender_ip;
    assign req.ready = (state_reg == arpc_pkg::S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    // result of the current item once the walk is over
    always_comb
    begin
        res = '0;
        if (item_reg.action == arpc_pkg::ACT_LOOKUP)
        begin
            if (found_reg)
            begin
                res.lookup_hit = 1'b1;
                res.lookup_mac = found_mac_reg;
            end
            else if (!item_reg.silent)
            begin
                res.send_valid    = 1'b1;
                res.send_kind     = arpc_pkg::KIND_REQUEST;
                res.send_dest_mac = arpc_pkg::MAC_BCAST;
                res.send_dest_ip  = item_reg.query_ip;
            end
        end
        else if (item_reg.frame_complete)
        begin
            res.insert_dropped = !found_reg && !free_reg;
            if (item_reg.oper == arpc_pkg::OPER_REQUEST && item_reg.tgt_ip == own_ip)
            begin
                res.send_valid    = 1'b1;
                res.send_kind     = arpc_pkg::KIND_REPLY;
                res.send_dest_mac = item_reg.sender_mac;
                res.send_dest_ip  = item_reg.sender_ip;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        cnt_next       = cnt_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        found_mac_next = found_mac_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        valid_next     = valid_reg;
        out_next       = out_reg;
        load           = 1'b0;
        tbl_cmd        = '0;

        case (state_reg)
            arpc_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    item_next  = req.data;
                    cnt_next   = '0;
                    found_next = 1'b0;
                    free_next  = 1'b0;
                    if (req.data.action == arpc_pkg::ACT_LOOKUP || req.data.frame_complete)
                    begin
                        state_next = arpc_pkg::S_SCAN;
                    end
                    else
                    begin
                        state_next = arpc_pkg::S_RESOLVE;
                    end
                end
            end

            arpc_pkg::S_SCAN:
            begin
                // read one entry a cycle, compare it the cycle after
                if (cnt_reg < arpc_pkg::CNT_W'(arpc_pkg::ENTRIES))
                begin
                    tbl_cmd.rd_en   = 1'b1;
                    tbl_cmd.rd_addr = cnt_reg[arpc_pkg::IDX_W-1:0];
                    pend_next       = 1'b1;
                    pend_idx_next   = cnt_reg[arpc_pkg::IDX_W-1:0];
                    cnt_next        = cnt_reg + arpc_pkg::CNT_W'(1);
                end
                if (pend_reg)
                begin
                    if (valid_reg[pend_idx_reg] && tbl_rd_data.ip == key && !found_reg)
                    begin
                        found_next     = 1'b1;
                        found_idx_next = pend_idx_reg;
                        found_mac_next = tbl_rd_data.mac;
                    end
                    if (!valid_reg[pend_idx_reg] && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = pend_idx_reg;
                    end
                end
                else if (!tbl_cmd.rd_en)
                begin
                    state_next = arpc_pkg::S_RESOLVE;
                end
            end

            arpc_pkg::S_RESOLVE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load       = 1'b1;
                    out_next   = res;
                    state_next = arpc_pkg::S_IDLE;
                    if (item_reg.action == arpc_pkg::ACT_PACKET && item_reg.frame_complete)
                    begin
                        tbl_cmd.wr_data.ip  = item_reg.sender_ip;
                        tbl_cmd.wr_data.mac = item_reg.sender_mac;
                        if (found_reg)
                        begin
                            tbl_cmd.wr_en   = 1'b1;
                            tbl_cmd.wr_addr = found_idx_reg;
                        end
                        else if (free_reg)
                        begin
                            tbl_cmd.wr_en           = 1'b1;
                            tbl_cmd.wr_addr         = free_idx_reg;
                            valid_next[free_idx_reg] = 1'b1;
                        end
                    end
                end
            end

            default:
            begin
                state_next = arpc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= arpc_pkg::S_IDLE;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            free_reg      <= 1'b0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            free_reg      <= free_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        pend_idx_reg  <= pend_idx_next;
        found_idx_reg <= found_idx_next;
        found_mac_reg <= found_mac_next;
        free_idx_reg  <= free_idx_next;
        out_reg       <= out_next;
    end

endmodule

// ----- rtl/arp_cache_and_responder.sv -----
// ----------------------------------------------------------------------------
// arp_cache_and_responder
// ARP cache with request responder and address lookup.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one word per item: a parsed received ARP packet (action 0)
//   or an IPv4 lookup (action 1). rsp returns exactly one word per item.
//   Configuration (own_ip at index 0, own_mac at index 1) is written through
//   cfg_we/cfg_idx/cfg_data while no item is in flight.
// Timing:
//   An item walks the whole table once through the registered memory read
//   port, one entry per cycle, then resolves and writes back once the
//   output register is free, which loads the result word. An incomplete
//   frame skips the walk. req.ready is high only while the sequencer is
//   idle, so no new item is taken until the last one has been resolved.
// Reset:
//   Clears all valid bits, own_ip and the output valid flag; table contents
//   are not cleared, and the block is ready straight after reset.
// Back-pressure:
//   The result sits in an output register; the next item may be accepted
//   and walked while it waits, and that item stalls at write-back until
//   rsp.ready takes the pending word.
// ----------------------------------------------------------------------------
module arp_cache_and_responder (
    input  logic                             clk,
    input  logic                             rst_n,
    arpc_req_if.sink                         req,
    arpc_rsp_if.source                       rsp,
    input  logic                             cfg_we,
    input  logic [arpc_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [arpc_pkg::CFG_W-1:0]       cfg_data
);

    logic [arpc_pkg::IP_W-1:0] own_ip_reg, own_ip_next;
    arpc_pkg::tbl_cmd_t        tbl_cmd;
    arpc_pkg::entry_t          tbl_rd_data;

    // own_mac is not used by any result field; writes to it are taken and dropped
    always_comb
    begin
        own_ip_next = own_ip_reg;
        if (cfg_we && cfg_idx == arpc_pkg::REG_OWN_IP)
        begin
            own_ip_next = cfg_data[arpc_pkg::IP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg <= '0;
        end
        else
        begin
            own_ip_reg <= own_ip_next;
        end
    end

    arpc_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .own_ip      (own_ip_reg),
        .tbl_cmd     (tbl_cmd),
        .tbl_rd_data (tbl_rd_data)
    );

    arpc_table u_table (
        .clk     (clk),
        .cmd     (tbl_cmd),
        .rd_data (tbl_rd_data)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("input taken while an item is in flight");

    a_hit_no_send: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.data.lookup_hit |-> !rsp.data.send_valid && !rsp.data.insert_dropped)
        else $error("lookup hit with send or drop flag");

    a_request_bcast: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.data.send_kind |->
            rsp.data.send_valid && rsp.data.send_dest_mac == arpc_pkg::MAC_BCAST)
        else $error("request word without broadcast destination");

    a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_cmd.wr_en |-> !tbl_cmd.rd_en && u_engine.state_reg == arpc_pkg::S_RESOLVE)
        else $error("table write outside write-back");

endmodule
